[rtl/lgge_pkg.sv]
// Shared constants and command codes for the life grid generation engine.
`default_nettype none

package lgge_pkg;

    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 64;

    localparam int CMD_W      = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

endpackage

`default_nettype wire

[rtl/lgge_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
`default_nettype none

module lgge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/life_grid_generation_engine.sv]
// Life grid generation engine: bounded grid of cells, cell access and generation step.
//
// The grid is GRID_ROWS row words of GRID_COLS cells, kept in two RAM banks (current and
// next generation) that swap after every advance. Per-row valid bits make the whole grid
// read as dead right after reset, so there is no clearing pass. Commands arrive on the
// s_ channel (s_tuser = command); each command other than code 3 gives exactly one result
// word on the m_ channel. One command is in flight at a time. A write or read offers its
// result after the RAM read at the accepting edge, then the update or pick, then the output
// register, and the next command is taken once the result has entered that register. An
// advance reads the current bank row by row: the single read port of the current bank
// delivers one row word per cycle, and one rule unit turns the window of three rows into
// one new row word per cycle, written to the other bank. Command 3 returns to idle and
// gives no result.
`default_nettype none

module life_grid_generation_engine
    import lgge_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [5:0] row, [11:6] col, [12] cell_in
    input  wire logic [CMD_W-1:0]     s_tuser,   // [1:0] command

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [0] cell_out
    output logic [CMD_W-1:0]          m_tuser    // [1:0] done_kind
);

    localparam int AW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int RX = ((AW > ROW_W) ? AW : ROW_W) + 1;
    localparam logic [RX-1:0]      ROWS_X   = RX'(GRID_ROWS);
    localparam logic [COL_W:0]     COLS_X   = (COL_W+1)'(GRID_COLS);
    localparam logic [AW-1:0]      LAST_ROW = AW'(GRID_ROWS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_ADV,
        ST_DRAIN,
        ST_TAIL,
        ST_DONE
    } state_t;

    typedef logic [GRID_COLS-1:0] row_t;

    state_t             state_reg, state_next;
    logic               cur_bank_reg, cur_bank_next;
    logic [GRID_ROWS-1:0] valid_a_reg, valid_a_next;
    logic [GRID_ROWS-1:0] valid_b_reg, valid_b_next;
    cmd_t               cmd_reg, cmd_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [CW-1:0]      col_reg, col_next;
    logic               val_reg, val_next;
    logic               inside_reg, inside_next;
    logic [AW-1:0]      rd_cnt_reg, rd_cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [AW-1:0]      rd_row_reg, rd_row_next;
    logic               rd_valid_reg, rd_valid_next;
    row_t               above_reg, above_next;
    row_t               mid_reg, mid_next;
    logic               res_cell_reg, res_cell_next;
    cmd_t               res_kind_reg, res_kind_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_cell_reg, m_cell_next;
    cmd_t               m_kind_reg, m_kind_next;

    // input unpacking
    logic [ROW_W-1:0]   in_row;
    logic [COL_W-1:0]   in_col;
    logic [RX-1:0]      in_row_x;
    logic               in_inside;
    logic               s_fire;

    // RAM ports
    logic [AW-1:0]      raddr;
    logic               wr_en;
    logic               wr_bank;
    logic [AW-1:0]      waddr;
    row_t               wdata;
    logic               we_a, we_b;
    row_t               rdata_a, rdata_b;
    row_t               row_data;
    logic               raddr_ok;

    // rule unit
    row_t               rule_above, rule_mid, rule_below, rule_out;
    logic [GRID_COLS+1:0] ext_above, ext_mid, ext_below;

    function automatic logic cell_next(input logic [2:0] up, input logic [2:0] md,
                                       input logic [2:0] dn);
        logic [3:0] n;
        n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(md[0]) + 4'(md[2])
          + 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
        return (n == 4'd3) || (md[1] && (n == 4'd2));
    endfunction

    assign in_row    = s_tdata[ROW_W-1:0];
    assign in_col    = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_row_x  = RX'(in_row);
    assign in_inside = (in_row_x < ROWS_X) && ({1'b0, in_col} < COLS_X);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;

    assign row_data  = rd_valid_reg ? (cur_bank_reg ? rdata_b : rdata_a) : '0;
    assign raddr_ok  = ({1'b0, raddr} < (AW+1)'(GRID_ROWS));

    // one new row word from the three-row window; cells off the edge are dead
    assign ext_above = {1'b0, rule_above, 1'b0};
    assign ext_mid   = {1'b0, rule_mid, 1'b0};
    assign ext_below = {1'b0, rule_below, 1'b0};

    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            rule_out[c] = cell_next(ext_above[c +: 3], ext_mid[c +: 3], ext_below[c +: 3]);
        end
    end

    assign rule_above = (state_reg == ST_TAIL) ? above_reg : above_reg;
    assign rule_mid   = mid_reg;
    assign rule_below = (state_reg == ST_TAIL) ? '0 : row_data;

    assign we_a = wr_en && !wr_bank;
    assign we_b = wr_en && wr_bank;

    lgge_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_bank_a (
        .clk   (aclk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    lgge_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_bank_b (
        .clk   (aclk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    always_comb begin
        state_next    = state_reg;
        cur_bank_next = cur_bank_reg;
        valid_a_next  = valid_a_reg;
        valid_b_next  = valid_b_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        col_next      = col_reg;
        val_next      = val_reg;
        inside_next   = inside_reg;
        rd_cnt_next   = rd_cnt_reg;
        rd_pend_next  = 1'b0;
        rd_row_next   = rd_row_reg;
        above_next    = above_reg;
        mid_next      = mid_reg;
        res_cell_next = res_cell_reg;
        res_kind_next = res_kind_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_cell_next   = m_cell_reg;
        m_kind_next   = m_kind_reg;

        raddr   = in_row_x[AW-1:0];
        wr_en   = 1'b0;
        wr_bank = cur_bank_reg;
        waddr   = addr_reg;
        wdata   = row_data;

        // row arriving from the current bank during an advance
        if (rd_pend_reg) begin
            if (rd_row_reg != '0) begin
                wr_en   = 1'b1;
                wr_bank = !cur_bank_reg;
                waddr   = rd_row_reg - AW'(1);
                wdata   = rule_out;
            end
            above_next = mid_reg;
            mid_next   = row_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next    = cmd_t'(s_tuser);
                    addr_next   = in_row_x[AW-1:0];
                    col_next    = in_col[CW-1:0];
                    val_next    = s_tdata[ROW_W+COL_W];
                    inside_next = in_inside;
                    rd_cnt_next = '0;
                    mid_next    = '0;
                    unique case (cmd_t'(s_tuser))
                        CMD_WRITE, CMD_READ: state_next = ST_RMW;
                        CMD_ADVANCE:         state_next = ST_ADV;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RMW: begin
                res_kind_next = cmd_reg;
                res_cell_next = 1'b0;
                if (cmd_reg == CMD_WRITE) begin
                    if (inside_reg) begin
                        wr_en          = 1'b1;
                        wr_bank        = cur_bank_reg;
                        waddr          = addr_reg;
                        wdata          = row_data;
                        wdata[col_reg] = val_reg;
                    end
                end else if (inside_reg) begin
                    res_cell_next = row_data[col_reg];
                end
                state_next = ST_DONE;
            end
            ST_ADV: begin
                raddr        = rd_cnt_reg;
                rd_pend_next = 1'b1;
                rd_row_next  = rd_cnt_reg;
                rd_cnt_next  = rd_cnt_reg + AW'(1);
                if (rd_cnt_reg == LAST_ROW) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_TAIL;
            end
            ST_TAIL: begin
                wr_en         = 1'b1;
                wr_bank       = !cur_bank_reg;
                waddr         = LAST_ROW;
                wdata         = rule_out;
                cur_bank_next = !cur_bank_reg;
                res_cell_next = 1'b0;
                res_kind_next = CMD_ADVANCE;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_cell_next  = res_cell_reg;
                    m_kind_next  = res_kind_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        rd_valid_next = raddr_ok &&
                        (cur_bank_reg ? valid_b_reg[raddr] : valid_a_reg[raddr]);

        if (wr_en && !wr_bank) valid_a_next[waddr] = 1'b1;
        if (wr_en && wr_bank)  valid_b_next[waddr] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_bank_reg <= 1'b0;
            valid_a_reg  <= '0;
            valid_b_reg  <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_bank_reg <= cur_bank_next;
            valid_a_reg  <= valid_a_next;
            valid_b_reg  <= valid_b_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        col_reg      <= col_next;
        val_reg      <= val_next;
        inside_reg   <= inside_next;
        rd_cnt_reg   <= rd_cnt_next;
        rd_row_reg   <= rd_row_next;
        rd_valid_reg <= rd_valid_next;
        above_reg    <= above_next;
        mid_reg      <= mid_next;
        res_cell_reg <= res_cell_next;
        res_kind_reg <= res_kind_next;
        m_cell_reg   <= m_cell_next;
        m_kind_reg   <= m_kind_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_cell_reg);
    assign m_tuser  = m_kind_reg;

    // the two banks are never written in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn) !(we_a && we_b))
        else $error("both grid banks written in one cycle");

    // an advance never writes the bank it is reading
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADV || state_reg == ST_DRAIN || state_reg == ST_TAIL) && wr_en
        |-> wr_bank != cur_bank_reg)
        else $error("advance wrote the current bank");

    // each advance swaps the banks exactly once, at its last row
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TAIL |=> cur_bank_reg != $past(cur_bank_reg))
        else $error("bank swap missing after advance");

    // only reads can return a live cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tuser == CMD_READ)
        else $error("live cell returned for a non-read command");

endmodule

`default_nettype wire
